/* hw/rtl/cfbb_pkg.sv */
package cfbb_pkg;

    // width of the batch tag kept beside each stored id
    localparam int EPOCH_BITS = 8;

    // command codes of the input word
    localparam logic CMD_TEST  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

/* hw/rtl/cfbb_cmd_if.sv */
interface cfbb_cmd_if #(
    parameter int BODY_ID_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [BODY_ID_BITS-1:0] body_a_id;
    logic                    body_a_movable;
    logic [BODY_ID_BITS-1:0] body_b_id;
    logic                    body_b_movable;

    modport source (
        output valid,
        output command,
        output body_a_id,
        output body_a_movable,
        output body_b_id,
        output body_b_movable,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  body_a_id,
        input  body_a_movable,
        input  body_b_id,
        input  body_b_movable,
        output ready
    );
endinterface

/* hw/rtl/cfbb_rsp_if.sv */
interface cfbb_rsp_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (
        output valid,
        output accepted,
        input  ready
    );

    modport sink (
        input  valid,
        input  accepted,
        output ready
    );
endinterface

/* hw/rtl/conflict_free_batch_builder.sv */
// Conflict-free batch builder: keeps the set of movable body ids claimed by the current batch in
// an open-addressed hash table (home slot = id modulo TABLE_ENTRIES, linear probing with wrap;
// TABLE_ENTRIES must be a power of two) held in one single-port-read RAM, and answers each test
// word with accepted = 1 when neither movable body is already in the batch, inserting them, or
// accepted = 0 otherwise, leaving the set as it was. A clear word starts a new batch and gives no
// result. A test word with two movable bodies and no collisions passes through accept, probe of
// the first body, reload of the RAM read port and probe of the second body; every further slot
// walked past adds a further probe, since the RAM delivers one slot per cycle, and a word with
// one movable body needs only the accept and its probe, with none only the accept. A clear word
// needs no sweep because entries carry a batch tag, but after reset and on every 255th clear the
// block sweeps the whole table, during which it accepts no word. A finished result sits in an
// output register, so the next word is taken while it waits.
module conflict_free_batch_builder #(
    parameter int TABLE_ENTRIES = 512,
    parameter int BODY_ID_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    cfbb_cmd_if.sink   cmd,
    cfbb_rsp_if.source rsp
);
    import cfbb_pkg::*;

    localparam int ADDR_BITS   = $clog2(TABLE_ENTRIES);
    localparam int WIDE_BITS   = (ADDR_BITS > BODY_ID_BITS) ? ADDR_BITS : BODY_ID_BITS;
    localparam int ENTRY_BITS  = EPOCH_BITS + BODY_ID_BITS;
    localparam logic [ADDR_BITS-1:0]  LAST_SLOT = ADDR_BITS'(TABLE_ENTRIES - 1);
    localparam logic [EPOCH_BITS-1:0] LAST_EPOCH = '1;

    localparam logic [2:0] ST_SWEEP   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_RUN     = 3'd2;
    localparam logic [2:0] ST_SETUP_B = 3'd3;
    localparam logic [2:0] ST_HOLD    = 3'd4;

    // home slot: id modulo table size
    function automatic logic [ADDR_BITS-1:0] home_slot(input logic [BODY_ID_BITS-1:0] id);
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(id);
        return wide[ADDR_BITS-1:0];
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [EPOCH_BITS-1:0]   epoch_reg, epoch_next;
    logic [ADDR_BITS-1:0]    sweep_addr_reg, sweep_addr_next;
    logic                    cur_is_b_reg, cur_is_b_next;
    logic                    slot_a_used_reg, slot_a_used_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    accepted_reg, accepted_next;
    logic                    ok_reg, ok_next;
    logic [ADDR_BITS-1:0]    chk_pos_reg, chk_pos_next;
    logic [ADDR_BITS-1:0]    count_reg, count_next;
    logic [ADDR_BITS-1:0]    slot_a_reg, slot_a_next;
    logic [BODY_ID_BITS-1:0] id_a_reg, id_a_next;
    logic [BODY_ID_BITS-1:0] id_b_reg, id_b_next;
    logic                    mov_b_reg, mov_b_next;

    logic                    wr_en;
    logic [ADDR_BITS-1:0]    wr_addr;
    logic [ENTRY_BITS-1:0]   wr_data;
    logic                    rd_en;
    logic [ADDR_BITS-1:0]    rd_addr;
    logic [ENTRY_BITS-1:0]   rd_data;

    logic                    cmd_fire;
    logic                    fin;
    logic                    fin_ok;
    logic                    can_load;
    logic [BODY_ID_BITS-1:0] cur_id;
    logic [EPOCH_BITS-1:0]   entry_epoch;
    logic [BODY_ID_BITS-1:0] entry_id;
    logic                    slot_empty;
    logic                    slot_hit;

    cfbb_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and slot decode
    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.accepted = accepted_reg;
    assign can_load    = !out_valid_reg || rsp.ready;

    assign cur_id      = cur_is_b_reg ? id_b_reg : id_a_reg;
    assign entry_epoch = rd_data[ENTRY_BITS-1 -: EPOCH_BITS];
    assign entry_id    = rd_data[BODY_ID_BITS-1:0];
    assign slot_empty  = (entry_epoch != epoch_reg);
    assign slot_hit    = !slot_empty && (entry_id == cur_id);

    // sequencer: sweep, accept, probe walk, insert, release
    always_comb
    begin
        state_next       = state_reg;
        epoch_next       = epoch_reg;
        sweep_addr_next  = sweep_addr_reg;
        cur_is_b_next    = cur_is_b_reg;
        slot_a_used_next = slot_a_used_reg;
        ok_next          = ok_reg;
        chk_pos_next     = chk_pos_reg;
        count_next       = count_reg;
        slot_a_next      = slot_a_reg;
        id_a_next        = id_a_reg;
        id_b_next        = id_b_reg;
        mov_b_next       = mov_b_reg;
        wr_en            = 1'b0;
        wr_addr          = chk_pos_reg;
        wr_data          = {epoch_reg, cur_id};
        rd_en            = 1'b0;
        rd_addr          = ADDR_BITS'(chk_pos_reg + 1'b1);
        fin              = 1'b0;
        fin_ok           = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_addr_reg;
                wr_data = '0;
                if (sweep_addr_reg == LAST_SLOT)
                begin
                    epoch_next = EPOCH_BITS'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = ADDR_BITS'(sweep_addr_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    id_a_next        = cmd.body_a_id;
                    id_b_next        = cmd.body_b_id;
                    mov_b_next       = cmd.body_b_movable;
                    slot_a_used_next = 1'b0;
                    count_next       = '0;
                    if (cmd.command == CMD_CLEAR)
                    begin
                        if (epoch_reg == LAST_EPOCH)
                        begin
                            sweep_addr_next = '0;
                            state_next      = ST_SWEEP;
                        end
                        else
                        begin
                            epoch_next = EPOCH_BITS'(epoch_reg + 1'b1);
                        end
                    end
                    else if (cmd.body_a_movable)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = home_slot(cmd.body_a_id);
                        chk_pos_next  = home_slot(cmd.body_a_id);
                        cur_is_b_next = 1'b0;
                        state_next    = ST_RUN;
                    end
                    else if (cmd.body_b_movable)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = home_slot(cmd.body_b_id);
                        chk_pos_next  = home_slot(cmd.body_b_id);
                        cur_is_b_next = 1'b1;
                        state_next    = ST_RUN;
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                // next slot is fetched speculatively while this one is checked
                rd_en = 1'b1;
                if (slot_empty)
                begin
                    wr_en = 1'b1;
                    if (!cur_is_b_reg)
                    begin
                        slot_a_next      = chk_pos_reg;
                        slot_a_used_next = 1'b1;
                        if (mov_b_reg)
                        begin
                            state_next = ST_SETUP_B;
                        end
                        else
                        begin
                            fin    = 1'b1;
                            fin_ok = 1'b1;
                        end
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end
                end
                else if (slot_hit || (count_reg == LAST_SLOT))
                begin
                    // deferred: give back the slot claimed for the first body
                    if (cur_is_b_reg && slot_a_used_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = slot_a_reg;
                        wr_data = '0;
                    end
                    fin    = 1'b1;
                    fin_ok = 1'b0;
                end
                else
                begin
                    chk_pos_next = ADDR_BITS'(chk_pos_reg + 1'b1);
                    count_next   = ADDR_BITS'(count_reg + 1'b1);
                end
            end
            ST_SETUP_B:
            begin
                rd_en         = 1'b1;
                rd_addr       = home_slot(id_b_reg);
                chk_pos_next  = home_slot(id_b_reg);
                count_next    = '0;
                cur_is_b_next = 1'b1;
                state_next    = ST_RUN;
            end
            ST_HOLD:
            begin
                fin    = 1'b1;
                fin_ok = ok_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the result to the output register or park it
        if (fin)
        begin
            ok_next    = fin_ok;
            state_next = can_load ? ST_IDLE : ST_HOLD;
        end
    end

    // output register
    always_comb
    begin
        accepted_next  = accepted_reg;
        out_valid_next = out_valid_reg;
        if (fin && can_load)
        begin
            out_valid_next = 1'b1;
            accepted_next  = fin_ok;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            epoch_reg       <= '0;
            sweep_addr_reg  <= '0;
            cur_is_b_reg    <= 1'b0;
            slot_a_used_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            ok_reg          <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            epoch_reg       <= epoch_next;
            sweep_addr_reg  <= sweep_addr_next;
            cur_is_b_reg    <= cur_is_b_next;
            slot_a_used_reg <= slot_a_used_next;
            out_valid_reg   <= out_valid_next;
            ok_reg          <= ok_next;
            count_reg       <= count_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        chk_pos_reg  <= chk_pos_next;
        slot_a_reg   <= slot_a_next;
        id_a_reg     <= id_a_next;
        id_b_reg     <= id_b_next;
        mov_b_reg    <= mov_b_next;
    end

    // tag zero marks released or swept slots and is never live
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP) |-> (epoch_reg != '0))
        else $error("batch tag zero outside sweep");

    // a clear either advances the tag or starts a sweep
    a_clear_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.command == CMD_CLEAR)) |=>
        ((epoch_reg == EPOCH_BITS'($past(epoch_reg) + 1'b1)) || (state_reg == ST_SWEEP)))
        else $error("clear did not start a new batch");

    // a parked result only exists while the output register is occupied
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("result parked with free output register");

    // a release write only follows a claim for the first body
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && wr_en && wr_data == '0) |-> (cur_is_b_reg && slot_a_used_reg))
        else $error("slot released without a claim");
endmodule

/* hw/rtl/cfbb_ram.sv */
module cfbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* tb/sv/tb_conflict_free_batch_builder.sv */
module tb_conflict_free_batch_builder;

    timeunit 1ns;
    timeprecision 1ps;

    import cfbb_pkg::*;

    localparam int TABLE_ENTRIES = 512;
    localparam int BODY_ID_BITS  = 16;
    localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
    localparam int HIGH_SPAN     = (1 << BODY_ID_BITS) / TABLE_ENTRIES;

    // probe outcomes other than a free slot index
    localparam int PROBE_HIT  = -1;
    localparam int PROBE_FULL = -2;

    // watchdog: cycles in a row with no word moving on either channel
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int TEST_TARGET = 300;
    localparam int EPOCH_CLEARS = 240;

    // idle modes, rotated while words are sent
    localparam int MODE_NONE   = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_SINK   = 2;
    localparam int MODE_BOTH   = 3;
    localparam int MODE_COUNT  = 4;
    localparam int MODE_SPAN   = 37;

    typedef logic [BODY_ID_BITS-1:0] body_id_t;

    typedef struct packed {
        logic     command;
        body_id_t a_id;
        logic     a_movable;
        body_id_t b_id;
        logic     b_movable;
    } body_pair_t;

    // predicted batch contents and verdicts still owed by the block
    class batch_scoreboard;
        bit       slot_used [TABLE_ENTRIES];
        body_id_t slot_body [TABLE_ENTRIES];
        bit       verdicts [$];
        int       errors;

        function new();
            errors = 0;
            empty_set();
        endfunction

        function void empty_set();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_body[i] = '0;
            end
        endfunction

        // home slot then linear walk with wrap
        function int find_slot(body_id_t body);
            int pos;
            int n;
            pos = int'(body % TABLE_ENTRIES);
            for (n = 0; n < TABLE_ENTRIES; n++)
            begin
                if (!slot_used[pos])
                    return pos;
                if (slot_body[pos] == body)
                    return PROBE_HIT;
                pos = (pos + 1) % TABLE_ENTRIES;
            end
            return PROBE_FULL;
        endfunction

        function void note_word(body_pair_t w);
            int slot_a;
            int slot_b;
            bit placed;
            bit a_claimed;
            placed = 1'b1;
            a_claimed = 1'b0;
            slot_a = 0;
            if (w.command == CMD_CLEAR)
            begin
                empty_set();
                return;
            end
            if (w.a_movable)
            begin
                slot_a = find_slot(w.a_id);
                if (slot_a < 0)
                    placed = 1'b0;
                else
                begin
                    slot_used[slot_a] = 1'b1;
                    slot_body[slot_a] = w.a_id;
                    a_claimed = 1'b1;
                end
            end
            if (placed && w.b_movable)
            begin
                slot_b = find_slot(w.b_id);
                if (slot_b < 0)
                    placed = 1'b0;
                else
                begin
                    slot_used[slot_b] = 1'b1;
                    slot_body[slot_b] = w.b_id;
                end
            end
            // a deferred constraint gives back the first body's slot
            if (!placed && a_claimed)
            begin
                slot_used[slot_a] = 1'b0;
                slot_body[slot_a] = '0;
            end
            verdicts = {verdicts, placed};
        endfunction

        function void check_result(logic accepted);
            bit want;
            if (verdicts.size() == 0)
            begin
                $error("accepted: expected no word, actual %0b", accepted);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (accepted !== want)
            begin
                $error("accepted: expected %0b, actual %0b", want, accepted);
                errors++;
            end
        endfunction

        function void check_drained();
            if (verdicts.size() != 0)
            begin
                $error("accepted: expected %0d more words, actual none", verdicts.size());
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cfbb_cmd_if #(.BODY_ID_BITS(BODY_ID_BITS)) cmd_bus ();
    cfbb_rsp_if rsp_bus ();

    conflict_free_batch_builder #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BODY_ID_BITS  (BODY_ID_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    batch_scoreboard sb;

    int src_idle_pct;
    int sink_stall_pct;
    int idle_mode;
    int words_sent;
    int tests_sent;
    int quiet_cycles;

    // per-batch pool of ids so that bodies repeat within a batch
    body_id_t crowd [6];
    logic [SLOT_BITS-1:0] cluster_slot;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watch both channels, predict and check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                sb.note_word({cmd_bus.command, cmd_bus.body_a_id, cmd_bus.body_a_movable,
                              cmd_bus.body_b_id, cmd_bus.body_b_movable});
            if (rsp_bus.valid && rsp_bus.ready)
                sb.check_result(rsp_bus.accepted);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_word(input body_pair_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.command        <= w.command;
        cmd_bus.body_a_id      <= w.a_id;
        cmd_bus.body_a_movable <= w.a_movable;
        cmd_bus.body_b_id      <= w.b_id;
        cmd_bus.body_b_movable <= w.b_movable;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (w.command == CMD_TEST)
            tests_sent++;
        // rotate idle mode
        if (words_sent % MODE_SPAN == 0)
        begin
            idle_mode = (idle_mode + 1) % MODE_COUNT;
            case (idle_mode)
                MODE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                MODE_SENDER: begin src_idle_pct = 80; sink_stall_pct = 0;  end
                MODE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 80; end
                MODE_BOTH:   begin src_idle_pct = 26; sink_stall_pct = 26; end
                default:     ;
            endcase
        end
    endtask

    task automatic send_test(input body_id_t a, input logic am, input body_id_t b,
                             input logic bm);
        send_word({CMD_TEST, a, am, b, bm});
    endtask

    // ignored fields carry random bits
    task automatic send_clear();
        send_word({CMD_CLEAR, BODY_ID_BITS'($urandom), 1'($urandom),
                   BODY_ID_BITS'($urandom), 1'($urandom)});
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(negedge clk);
        while (sb.verdicts.size() != 0)
            @(negedge clk);
    endtask

    function automatic void refill_crowd();
        body_id_t id;
        cluster_slot = ($urandom_range(3) == 0) ? SLOT_BITS'(TABLE_ENTRIES - 1 - $urandom_range(7))
                                                : SLOT_BITS'($urandom);
        foreach (crowd[i])
        begin
            id = BODY_ID_BITS'($urandom);
            if ($urandom_range(1) == 0)
                id[SLOT_BITS-1:0] = cluster_slot + SLOT_BITS'($urandom_range(2));
            crowd[i] = id;
        end
    endfunction

    function automatic body_id_t pick_body();
        body_id_t id;
        id = BODY_ID_BITS'($urandom);
        case ($urandom_range(9))
            0:       id = '0;
            1:       id = '1;
            2, 3, 4: id = crowd[$urandom_range(5)];
            5, 6:    id[SLOT_BITS-1:0] = cluster_slot;
            default: ;
        endcase
        return id;
    endfunction

    initial
    begin
        int n;
        int k;
        int batch;
        body_id_t last_id;

        sb = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        idle_mode      = MODE_NONE;
        words_sent     = 0;
        tests_sent     = 0;
        quiet_cycles   = 0;
        last_id        = '0;
        rst_n                  = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.command        = CMD_TEST;
        cmd_bus.body_a_id      = '0;
        cmd_bus.body_a_movable = 1'b0;
        cmd_bus.body_b_id      = '0;
        cmd_bus.body_b_movable = 1'b0;
        rsp_bus.ready          = 1'b0;
        refill_crowd();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // immovable bodies never collide
        send_test(16'h0000, 1'b0, 16'hFFFF, 1'b0);
        send_test(16'h0000, 1'b1, 16'hFFFF, 1'b1);
        send_test(16'h0000, 1'b1, 16'h0005, 1'b0);
        send_test(16'h0007, 1'b0, 16'hFFFF, 1'b1);
        // same body on both sides is deferred and leaves nothing behind
        send_test(16'h0064, 1'b1, 16'h0064, 1'b1);
        send_test(16'h0064, 1'b1, 16'h1234, 1'b0);
        // second body rejected, first body's slot released
        send_test(16'h00C8, 1'b1, 16'h0000, 1'b1);
        send_test(16'h00C8, 1'b1, 16'h00C9, 1'b0);
        // collisions at slot 0, walk past occupied slots and wrap from the top
        send_test(16'h0200, 1'b1, 16'h0001, 1'b1);
        send_test(16'h0201, 1'b1, 16'hC000, 1'b0);
        send_test(16'h03FF, 1'b1, 16'h0000, 1'b0);
        send_test(16'h03FF, 1'b0, 16'h03FF, 1'b1);
        send_test(16'hFE00, 1'b1, 16'h0201, 1'b1);
        send_test(16'hFE00, 1'b1, 16'h0000, 1'b0);
        // new batch empties the set
        send_clear();
        send_test(16'h0000, 1'b1, 16'hFFFF, 1'b1);
        send_test(16'hAAAA, 1'b1, 16'h5555, 1'b1);
        send_test(16'h5555, 1'b0, 16'hAAAA, 1'b0);
        send_test(16'hAAAA, 1'b0, 16'h5555, 1'b1);
        wait_drained();
        send_clear();
        send_test(16'h5555, 1'b1, 16'hAAAA, 1'b1);

        // random batches
        for (batch = 0; tests_sent < TEST_TARGET || batch <= 20; batch++)
        begin
            if ($urandom_range(9) == 0)
                wait_drained();
            send_clear();
            refill_crowd();
            if (batch == 8)
            begin
                // fill every slot, then probe the full set
                for (k = 0; k < TABLE_ENTRIES / 2; k++)
                begin
                    last_id = BODY_ID_BITS'(2 * k + 1 + TABLE_ENTRIES * $urandom_range(HIGH_SPAN - 1));
                    send_test(BODY_ID_BITS'(2 * k + TABLE_ENTRIES * $urandom_range(HIGH_SPAN - 1)),
                              1'b1, last_id, 1'b1);
                end
                wait_drained();
                send_test(BODY_ID_BITS'($urandom), 1'b1, BODY_ID_BITS'($urandom), 1'b0);
                send_test(BODY_ID_BITS'($urandom), 1'b0, BODY_ID_BITS'($urandom), 1'b1);
                send_test(BODY_ID_BITS'($urandom), 1'b0, BODY_ID_BITS'($urandom), 1'b0);
                send_test(last_id, 1'b1, BODY_ID_BITS'($urandom), 1'b0);
            end
            else if (batch == 20)
            begin
                // long run of short batches, crossing the batch tag wrap
                for (k = 0; k < EPOCH_CLEARS; k++)
                begin
                    send_clear();
                    if ($urandom_range(99) < 15)
                        send_test(crowd[$urandom_range(5)], 1'b1, crowd[$urandom_range(5)],
                                  1'($urandom));
                end
            end
            else
            begin
                n = ($urandom_range(4) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    send_test(pick_body(), ($urandom_range(4) != 0),
                              pick_body(), ($urandom_range(4) != 0));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
